>>> hw/rtl/d3lm_pkg.sv
// d3lm_pkg: types and constants for the directed 3-D local max probe.
// No dependencies.
`default_nettype none
package d3lm_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_H      = 2'd1,
        OP_HT     = 2'd2,
        OP_PROBE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_SIZE_X    = 2'd1,
        REG_SIZE_Y    = 2'd2,
        REG_SIZE_Z    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         x;
        logic [4:0]         y;
        logic [2:0]         z;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [14:0] voxel_index;
        logic        is_max;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CENTER,
        ST_DIRECT,
        ST_DCMP,
        ST_SUMRD,
        ST_SUMACC,
        ST_SUMLAST,
        ST_SUMDRAIN,
        ST_SUMCMP,
        ST_DONE
    } state_t;

    localparam int CFG_W = 16;
    localparam int ACC_W = 40;

endpackage
`default_nettype wire

>>> hw/rtl/directed_3d_local_max_probe.sv
// directed_3d_local_max_probe: top level, volume and weight stores, probe sequencer.
// Depends on d3lm_pkg.
`default_nettype none
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_ready  d3lm_pkg::in_item_t
// out       output     out_valid/out_ready d3lm_pkg::out_item_t
// cfg       input      cfg_we             cfg_index, cfg_data
//
// Loads are written on acceptance and can follow back to back. A probe reads the
// center, then eight direct neighbors (states DIRECT and DCMP for each), then 18
// weighted sums of size_y terms with one shared multiplier (states SUMRD, SUMACC,
// SUMLAST, SUMDRAIN and SUMCMP for each). Stores are not cleared at reset. in_ready
// is low from acceptance of a probe until its result is taken; a probe outside the
// size returns no result. A stalled output holds the block.
module directed_3d_local_max_probe #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 32,
    parameter int MAX_Z = 8
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire d3lm_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire                    out_ready,
    output d3lm_pkg::out_item_t    out_item,
    input  wire                    cfg_we,
    input  wire [1:0]              cfg_index,
    input  wire [d3lm_pkg::CFG_W-1:0] cfg_data
);
    localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int VA = XW + YW + ZW;
    localparam int WA = 2 * YW;
    localparam int SXW = $clog2(MAX_X + 1);
    localparam int SYW = $clog2(MAX_Y + 1);
    localparam int SZW = $clog2(MAX_Z + 1);
    localparam int ACC = d3lm_pkg::ACC_W;

    // Memories
    logic signed [15:0] vol_mem [0:(1 << VA) - 1];
    logic signed [15:0] h_mem   [0:(1 << WA) - 1];
    logic signed [15:0] ht_mem  [0:(1 << WA) - 1];

    // Config
    logic signed [15:0] thr_reg;
    logic [SXW-1:0] sx_reg;
    logic [SYW-1:0] sy_reg;
    logic [SZW-1:0] sz_reg;

    function automatic logic [15:0] clampv(input logic [15:0] v, input int hi);
        logic [15:0] r;
        begin
            r = v;
            if (v < 16'd3) r = 16'd3;
            else if (v > 16'(hi)) r = 16'(hi);
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= -16'sd32768;
            sx_reg  <= SXW'(MAX_X < 64 ? MAX_X : 64);
            sy_reg  <= SYW'(MAX_Y < 32 ? MAX_Y : 32);
            sz_reg  <= SZW'(MAX_Z < 8 ? MAX_Z : 8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                d3lm_pkg::REG_THRESHOLD: thr_reg <= cfg_data;
                d3lm_pkg::REG_SIZE_X: sx_reg <= SXW'(clampv({9'd0, cfg_data[6:0]}, MAX_X));
                d3lm_pkg::REG_SIZE_Y: sy_reg <= SYW'(clampv({10'd0, cfg_data[5:0]}, MAX_Y));
                d3lm_pkg::REG_SIZE_Z: sz_reg <= SZW'(clampv({12'd0, cfg_data[3:0]}, MAX_Z));
                default: ;
            endcase
        end
    end

    // Sequencer state
    d3lm_pkg::state_t state_reg, state_next;
    d3lm_pkg::in_item_t it_reg;
    logic ok_reg, ok_next;
    logic [14:0] idx_reg;
    logic signed [15:0] s_reg;
    logic [2:0] dn_reg, dn_next;        // direct neighbor 0..7
    logic [4:0] sn_reg, sn_next;        // weighted sum 0..17
    logic [SYW-1:0] k_reg, k_next;
    logic signed [ACC-1:0] acc_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] vrd_reg, wrd_reg;
    logic prod_v_reg;

    // neighbor coordinates
    logic [XW:0] nx;
    logic [ZW:0] nz;
    always_comb
    begin
        nx = {1'b0, it_reg.x[XW-1:0]};
        nz = {1'b0, it_reg.z[ZW-1:0]};
        if (state_reg == d3lm_pkg::ST_DIRECT || state_reg == d3lm_pkg::ST_DCMP)
        begin
            case (dn_reg)
                3'd0: begin nx = nx + 1'b1; nz = nz - 1'b1; end
                3'd1: begin nx = nx - 1'b1; nz = nz - 1'b1; end
                3'd2: begin nx = nx + 1'b1; end
                3'd3: begin nx = nx - 1'b1; end
                3'd4: begin nx = nx + 1'b1; nz = nz + 1'b1; end
                3'd5: begin nx = nx - 1'b1; nz = nz + 1'b1; end
                3'd6: begin nz = nz - 1'b1; end
                default: begin nz = nz + 1'b1; end
            endcase
        end
        else
        begin
            // sum sn: t = sn/6, c = (sn/2)%3 ; bit0 selects HT
            case (sn_reg[4:1])
                4'd0, 4'd3, 4'd6: ;
                4'd1, 4'd4, 4'd7: nx = nx + 1'b1;
                default: nx = nx - 1'b1;
            endcase
            if (sn_reg < 5'd6) nz = nz - 1'b1;
            else if (sn_reg >= 5'd12) nz = nz + 1'b1;
        end
    end

    logic [VA-1:0] vaddr;
    logic [YW-1:0] vy;
    always_comb
    begin
        vy = it_reg.y[YW-1:0];
        if (state_reg == d3lm_pkg::ST_SUMRD || state_reg == d3lm_pkg::ST_SUMACC)
            vy = k_reg[YW-1:0];
        if (state_reg == d3lm_pkg::ST_CHECK)
            vaddr = {it_reg.z[ZW-1:0], it_reg.y[YW-1:0], it_reg.x[XW-1:0]};
        else
            vaddr = {nz[ZW-1:0], vy, nx[XW-1:0]};
    end
    logic [WA-1:0] waddr;
    assign waddr = {k_reg[YW-1:0], it_reg.y[YW-1:0]};

    // Accept / loads
    logic acc_in;
    assign in_ready = (state_reg == d3lm_pkg::ST_IDLE);
    assign acc_in = in_valid && in_ready;

    logic ld_ok_v, ld_ok_w;
    assign ld_ok_v = (32'(in_item.x) < MAX_X) && (32'(in_item.y) < MAX_Y)
                   && (32'(in_item.z) < MAX_Z);
    assign ld_ok_w = (32'(in_item.x) < MAX_Y) && (32'(in_item.y) < MAX_Y);

    always_ff @(posedge clk)
    begin
        if (acc_in && in_item.op == d3lm_pkg::OP_SAMPLE && ld_ok_v)
            vol_mem[{in_item.z[ZW-1:0], in_item.y[YW-1:0], in_item.x[XW-1:0]}]
                <= in_item.value;
        if (acc_in && in_item.op == d3lm_pkg::OP_H && ld_ok_w)
            h_mem[{in_item.x[YW-1:0], in_item.y[YW-1:0]}] <= in_item.value;
        if (acc_in && in_item.op == d3lm_pkg::OP_HT && ld_ok_w)
            ht_mem[{in_item.x[YW-1:0], in_item.y[YW-1:0]}] <= in_item.value;
        vrd_reg <= vol_mem[vaddr];
        wrd_reg <= sn_reg[0] ? ht_mem[waddr] : h_mem[waddr];
    end

    // index and bounds of the probe
    logic interior;
    logic in_x, in_y, in_z;
    assign in_x = 32'(it_reg.x) < 32'(sx_reg);
    assign in_y = 32'(it_reg.y) < 32'(sy_reg);
    assign in_z = 32'(it_reg.z) < 32'(sz_reg);
    assign interior = (it_reg.x != 0) && (32'(it_reg.x) + 2 <= 32'(sx_reg))
                   && (it_reg.y != 0) && (32'(it_reg.y) + 2 <= 32'(sy_reg))
                   && (it_reg.z != 0) && (32'(it_reg.z) + 2 <= 32'(sz_reg));
    logic [14:0] sxy_reg;

    // Shared multiplier (registered) and comparator
    logic signed [ACC-1:0] s15;
    assign s15 = ACC'(s_reg) <<< 15;

    always_comb
    begin
        state_next = state_reg;
        ok_next = ok_reg;
        dn_next = dn_reg;
        sn_next = sn_reg;
        k_next = k_reg;
        case (state_reg)
            d3lm_pkg::ST_IDLE:
                if (acc_in && in_item.op == d3lm_pkg::OP_PROBE)
                    state_next = d3lm_pkg::ST_CHECK;
            d3lm_pkg::ST_CHECK:
            begin
                ok_next = interior;
                dn_next = '0;
                sn_next = '0;
                if (!(in_x && in_y && in_z)) state_next = d3lm_pkg::ST_IDLE;
                else if (!interior) state_next = d3lm_pkg::ST_DONE;
                else state_next = d3lm_pkg::ST_CENTER;
            end
            d3lm_pkg::ST_CENTER:
            begin
                ok_next = vrd_reg >= thr_reg;
                state_next = (vrd_reg >= thr_reg) ? d3lm_pkg::ST_DIRECT : d3lm_pkg::ST_DONE;
            end
            d3lm_pkg::ST_DIRECT: state_next = d3lm_pkg::ST_DCMP;
            d3lm_pkg::ST_DCMP:
            begin
                dn_next = dn_reg + 3'd1;
                k_next = '0;
                if (!(s_reg > vrd_reg))
                begin
                    ok_next = 1'b0;
                    state_next = d3lm_pkg::ST_DONE;
                end
                else if (dn_reg == 3'd7) state_next = d3lm_pkg::ST_SUMRD;
                else state_next = d3lm_pkg::ST_DIRECT;
            end
            d3lm_pkg::ST_SUMRD:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == sy_reg) state_next = d3lm_pkg::ST_SUMLAST;
                else state_next = d3lm_pkg::ST_SUMACC;
            end
            d3lm_pkg::ST_SUMACC:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 == sy_reg) state_next = d3lm_pkg::ST_SUMLAST;
            end
            d3lm_pkg::ST_SUMLAST: state_next = d3lm_pkg::ST_SUMDRAIN;
            d3lm_pkg::ST_SUMDRAIN: state_next = d3lm_pkg::ST_SUMCMP;
            d3lm_pkg::ST_SUMCMP:
            begin
                k_next = '0;
                sn_next = sn_reg + 5'd1;
                if (!(s15 > acc_reg))
                begin
                    ok_next = 1'b0;
                    state_next = d3lm_pkg::ST_DONE;
                end
                else if (sn_reg == 5'd17) state_next = d3lm_pkg::ST_DONE;
                else state_next = d3lm_pkg::ST_SUMRD;
            end
            d3lm_pkg::ST_DONE:
                if (out_ready) state_next = d3lm_pkg::ST_IDLE;
            default: state_next = d3lm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid = (state_reg == d3lm_pkg::ST_DONE);
        out_item.voxel_index = idx_reg;
        out_item.is_max = ok_reg;
    end

    // pipeline flags: read (k) -> data/weight regs -> product -> accumulate
    logic rd_v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= d3lm_pkg::ST_IDLE;
            ok_reg <= 1'b0;
            dn_reg <= '0;
            sn_reg <= '0;
            k_reg <= '0;
            rd_v_reg <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg <= ok_next;
            dn_reg <= dn_next;
            sn_reg <= sn_next;
            k_reg <= k_next;
            rd_v_reg <= (state_reg == d3lm_pkg::ST_SUMRD) || (state_reg == d3lm_pkg::ST_SUMACC);
            prod_v_reg <= rd_v_reg;
        end
    end

    // sxy_reg follows the size registers; the user must change them only while idle, the block does not enforce it.
    always_ff @(posedge clk)
    begin
        if (acc_in) it_reg <= in_item;
        sxy_reg <= 15'(sx_reg) * 15'(sy_reg);
        if (state_reg == d3lm_pkg::ST_CENTER)
            s_reg <= vrd_reg;
        if (state_reg == d3lm_pkg::ST_CHECK)
            idx_reg <= 15'(it_reg.x) + 15'(sx_reg) * 15'(it_reg.y)
                       + sxy_reg * 15'(it_reg.z) + 15'd1;
        prod_reg <= vrd_reg * wrd_reg;
        if (state_reg == d3lm_pkg::ST_SUMRD)
            acc_reg <= '0;
        else if (prod_v_reg)
            acc_reg <= acc_reg + ACC'(prod_reg);
    end

    // The last read issues in SUMRD/SUMACC; the data lands in vrd_reg/wrd_reg, then the
    // product in prod_reg, then the accumulator. SUMLAST and SUMDRAIN cover that, so SUMCMP
    // sees the complete sum.

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !interior) |-> !out_item.is_max)
        else $error("border voxel flagged as max");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != d3lm_pkg::ST_IDLE) |-> !in_ready)
        else $error("ready while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.voxel_index != 15'd0)
        else $error("zero voxel index");
endmodule
`default_nettype wire

>>> tb/testbench.sv
// testbench: self-checking bench for directed_3d_local_max_probe.
// Depends on d3lm_pkg and the block's RTL; needs nothing else.
`default_nettype none
module testbench;
    import d3lm_pkg::*;

    localparam int VOL_N = 64 * 32 * 8;
    localparam int W_N = 32 * 32;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE = 40;

    // idle modes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct {
        in_item_t item;
        bit       drain_first;  // hold this item until all results are back
    } pend_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_item;
    logic out_valid;
    logic out_ready;
    out_item_t out_item;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    directed_3d_local_max_probe DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------- predictor state (updated at acceptance) ----------------
    logic signed [15:0] vol_mem [0:VOL_N-1];
    logic signed [15:0] h_mem [0:W_N-1];
    logic signed [15:0] ht_mem [0:W_N-1];
    logic signed [15:0] thr_reg = -16'sd32768;
    int sx_reg = 64;
    int sy_reg = 32;
    int sz_reg = 8;

    out_item_t expected_results[$];
    pend_t pending[$];

    int fail_count = 0;
    int probes_seen = 0;
    int maxima_seen = 0;
    int idle_mode = IDLE_NONE;
    int hold_token = 0;
    bit in_taken = 1'b0;

    // ---------------- stimulus planning state (updated at queue time) --------
    bit vol_set [0:VOL_N-1];
    bit h_set [0:W_N-1];
    bit ht_set [0:W_N-1];
    int plan_sx = 64;
    int plan_sy = 32;
    int plan_sz = 8;

    function automatic int clamp_size(int v, int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int vaddr(int x, int y, int z);
        return x + 64 * (y + 32 * z);
    endfunction

    // One H or HT weighted sum along y of column c in layer z, exact.
    function automatic longint weighted_sum(bit use_ht, int y, int c, int z);
        longint acc;
        acc = 0;
        for (int k = 0; k < sy_reg; k++)
        begin
            if (use_ht)
                acc += longint'(ht_mem[k * 32 + y]) * longint'(vol_mem[vaddr(c, k, z)]);
            else
                acc += longint'(h_mem[k * 32 + y]) * longint'(vol_mem[vaddr(c, k, z)]);
        end
        return acc;
    endfunction

    // Apply one accepted item to the model and queue its result, if any.
    function automatic void apply_item(in_item_t it);
        int x, y, z, zz;
        bit peak;
        logic signed [15:0] s;
        longint s15;
        out_item_t r;
        x = it.x;
        y = it.y;
        z = it.z;
        case (op_t'(it.op))
            OP_SAMPLE: vol_mem[vaddr(x, y, z)] = it.value;
            OP_H: if (x < 32) h_mem[x * 32 + y] = it.value;
            OP_HT: if (x < 32) ht_mem[x * 32 + y] = it.value;
            default:
            begin
                if (x >= sx_reg || y >= sy_reg || z >= sz_reg)
                    return;
                peak = x >= 1 && x + 2 <= sx_reg && y >= 1 && y + 2 <= sy_reg &&
                       z >= 1 && z + 2 <= sz_reg;
                if (peak)
                begin
                    s = vol_mem[vaddr(x, y, z)];
                    s15 = longint'(s) * 32768;
                    peak = s >= thr_reg;
                    for (int t = -1; t <= 1; t++)
                    begin
                        zz = z + t;
                        if (!(s > vol_mem[vaddr(x + 1, y, zz)]) ||
                            !(s > vol_mem[vaddr(x - 1, y, zz)]))
                            peak = 0;
                        if (t != 0 && !(s > vol_mem[vaddr(x, y, zz)]))
                            peak = 0;
                        for (int c = -1; c <= 1; c++)
                        begin
                            if (!(s15 > weighted_sum(0, y, x + c, zz)) ||
                                !(s15 > weighted_sum(1, y, x + c, zz)))
                                peak = 0;
                        end
                    end
                end
                r.voxel_index = 15'(x + sx_reg * y + sx_reg * sy_reg * z + 1);
                r.is_max = peak;
                expected_results.push_back(r);
            end
        endcase
    endfunction

    // ---------------- monitor: acceptance, config, result check ----------------
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if (rst_n && cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_THRESHOLD: thr_reg <= cfg_data;
                REG_SIZE_X: sx_reg <= clamp_size(int'(cfg_data[6:0]), 64);
                REG_SIZE_Y: sy_reg <= clamp_size(int'(cfg_data[5:0]), 32);
                default: sz_reg <= clamp_size(int'(cfg_data[3:0]), 8);
            endcase
        end
        if (rst_n && in_valid && in_ready)
            apply_item(in_item);
        if (rst_n && out_valid && out_ready)
        begin
            probes_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result index=%0d is_max=%0b", $time,
                         out_item.voxel_index, out_item.is_max);
                fail_count++;
            end
            else
            begin
                if (out_item.voxel_index !== expected_results[0].voxel_index)
                begin
                    $display("%0t: voxel_index expected %0d actual %0d", $time,
                             expected_results[0].voxel_index, out_item.voxel_index);
                    fail_count++;
                end
                if (out_item.is_max !== expected_results[0].is_max)
                begin
                    $display("%0t: is_max at index %0d expected %0b actual %0b", $time,
                             expected_results[0].voxel_index, expected_results[0].is_max,
                             out_item.is_max);
                    fail_count++;
                end
                if (expected_results[0].is_max)
                    maxima_seen++;
                void'(expected_results.pop_front());
            end
        end
    end

    // ---------------- driver: presents pending items on the input channel -----
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending.size() != 0 &&
                !((idle_mode == IDLE_SEND && $urandom_range(99) < 85) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(99) < 28)) &&
                (!pending[0].drain_first || expected_results.size() == 0))
            begin
                in_item <= pending[0].item;
                in_valid <= 1'b1;
                void'(pending.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------- receiver: random stalls plus one long hold-off ---------
    int hold_left = 0;
    int hold_seen = 0;
    always @(negedge clk)
    begin
        if (hold_seen != hold_token)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 85) ||
                           (idle_mode == IDLE_BOTH && $urandom_range(99) < 28));
    end

    // ---------------- stimulus helpers ----------------
    task automatic add_item(op_t op, int x, int y, int z, int value, bit drain = 0);
        pend_t p;
        p.item.op = op;
        p.item.x = 6'(x);
        p.item.y = 5'(y);
        p.item.z = 3'(z);
        p.item.value = 16'(value);
        p.drain_first = drain;
        pending.push_back(p);
        case (op)
            OP_SAMPLE: vol_set[vaddr(p.item.x, p.item.y, p.item.z)] = 1;
            OP_H: if (p.item.x < 32) h_set[p.item.x * 32 + p.item.y] = 1;
            OP_HT: if (p.item.x < 32) ht_set[p.item.x * 32 + p.item.y] = 1;
            default: ;
        endcase
    endtask

    function automatic int rand_s16();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Load anything an interior probe would read that was never written.
    task automatic cover_probe(int x, int y, int z);
        if (!(x >= 1 && x + 2 <= plan_sx && y >= 1 && y + 2 <= plan_sy &&
              z >= 1 && z + 2 <= plan_sz))
            return;
        for (int k = 0; k < plan_sy; k++)
        begin
            if (!h_set[k * 32 + y])
                add_item(OP_H, k, y, 0, rand_s16());
            if (!ht_set[k * 32 + y])
                add_item(OP_HT, k, y, 0, rand_s16());
            for (int c = -1; c <= 1; c++)
                for (int t = -1; t <= 1; t++)
                    if (!vol_set[vaddr(x + c, k, z + t)])
                        add_item(OP_SAMPLE, x + c, k, z + t, rand_s16());
        end
    endtask

    // Well-formed peak: bright center, dimmer neighborhood, small weights.
    task automatic add_peak();
        int x, y, z, s, wmax, v;
        x = $urandom_range(plan_sx - 2, 1);
        y = $urandom_range(plan_sy - 2, 1);
        z = $urandom_range(plan_sz - 2, 1);
        s = ($urandom_range(7) == 0) ? 32767 : $urandom_range(32767, 16384);
        wmax = 16384 / plan_sy;
        for (int k = 0; k < plan_sy; k++)
        begin
            add_item(OP_H, k, y, 0, $urandom_range(2 * wmax) - wmax);
            add_item(OP_HT, k, y, 0, $urandom_range(2 * wmax) - wmax);
            for (int c = -1; c <= 1; c++)
                for (int t = -1; t <= 1; t++)
                    if (!(c == 0 && t == 0 && k == y))
                    begin
                        v = $urandom_range(s - 1 + 32768) - 32768;
                        add_item(OP_SAMPLE, x + c, k, z + t, v);
                    end
        end
        add_item(OP_SAMPLE, x, y, z, s);
        // now and then tie a direct neighbor with the center to break strictness
        if ($urandom_range(3) == 0)
            add_item(OP_SAMPLE, x + ($urandom_range(1) ? 1 : -1), y,
                     z + $urandom_range(2) - 1, s);
        add_item(OP_PROBE, x, y, z, rand_s16());
    endtask

    task automatic add_random(int count);
        int x, y, z, r, start;
        start = pending.size();
        while (pending.size() - start < count)
        begin
            r = $urandom_range(99);
            if (r < 40)
                add_peak();
            else if (r < 60)
            begin
                x = $urandom_range(63);
                y = $urandom_range(31);
                z = $urandom_range(7);
                cover_probe(x, y, z);
                add_item(OP_PROBE, x, y, z, rand_s16(), $urandom_range(19) == 0);
            end
            else if (r < 85)
                add_item(op_t'($urandom_range(2)), $urandom_range(63), $urandom_range(31),
                         $urandom_range(7), rand_s16());
            else
            begin
                x = $urandom_range(plan_sx - 1);
                y = $urandom_range(plan_sy - 1);
                z = $urandom_range(plan_sz - 1);
                cover_probe(x, y, z);
                add_item(OP_PROBE, x, y, z, rand_s16());
            end
        end
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_phase(int thr, int sx, int sy, int sz, int mode);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        plan_sx = clamp_size(sx & 'h7f, 64);
        plan_sy = clamp_size(sy & 'h3f, 32);
        plan_sz = clamp_size(sz & 'hf, 8);
        idle_mode = mode;
    endtask

    // ---------------- main sequence ----------------
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every op, ignored weight loads, border probes
        add_item(OP_SAMPLE, 63, 31, 7, -32768);
        add_item(OP_SAMPLE, 0, 0, 0, 32767);
        add_item(OP_SAMPLE, 42, 21, 5, 0);
        add_item(OP_H, 31, 31, 0, 32767);
        add_item(OP_H, 0, 0, 7, -32768);
        add_item(OP_HT, 31, 0, 0, -1);
        add_item(OP_HT, 63, 31, 7, 12345);   // column beyond matrix: ignored
        add_item(OP_H, 32, 5, 2, -12345);    // ignored too
        cover_probe(42, 21, 5);
        add_item(OP_PROBE, 0, 0, 0, 0);
        add_item(OP_PROBE, 63, 31, 7, -1);
        add_item(OP_PROBE, 42, 21, 5, 32767);
        add_item(OP_PROBE, 63, 0, 0, 0);
        add_item(OP_PROBE, 0, 31, 7, 0);
        wait_drained();

        // smallest volume, no stalls
        set_phase(-32768, 3, 3, 3, IDLE_NONE);
        add_random(150);
        wait_drained();

        set_phase(0, 8, 5, 4, IDLE_SEND);
        add_random(150);
        wait_drained();

        // sizes below the floor act as 3
        set_phase(10000, 2, 1, 0, IDLE_RECV);
        add_random(120);
        wait_drained();

        // sizes above the parameters act as the maximum
        set_phase(-100, 127, 63, 15, IDLE_BOTH);
        add_random(260);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        set_phase(32767, 16, 6, 5, IDLE_NONE);
        add_random(150);
        hold_token = hold_token + 1;
        wait_drained();

        set_phase(5000, 10, 4, 8, IDLE_BOTH);
        add_random(150);
        wait_drained();

        $display("covered %0d probe results, %0d of them maxima, over 7 size settings",
                 probes_seen, maxima_seen);
        if (fail_count == 0)
            $display("directed_3d_local_max_probe verification clean");
        else
            $display("directed_3d_local_max_probe verification failed");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("directed_3d_local_max_probe verification failed");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/d3lm_pkg.sv
hw/rtl/directed_3d_local_max_probe.sv
tb/testbench.sv
